// ===== rtl/nmea_line_framer_unit_macros.svh =====
// Assertion helpers shared by the framer RTL.
`ifndef NMEA_LINE_FRAMER_UNIT_MACROS_SVH
`define NMEA_LINE_FRAMER_UNIT_MACROS_SVH

// Checked only outside reset.
`define NLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define NLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/nlf_pkg.sv =====
package nlf_pkg;

  // Default line capacity; lines of up to LINE_MAX_DEF-1 bytes are kept.
  localparam int unsigned LINE_MAX_DEF = 64;

  typedef logic [7:0] byte_t;

  // Framing characters
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_HASH   = 8'h23;

endpackage

// ===== rtl/nlf_if.sv =====
// Received byte channel
interface nlf_rx_if;
  logic             valid;
  logic             ready;
  nlf_pkg::byte_t   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Sentence byte channel
interface nlf_sent_if;
  logic             valid;
  logic             ready;
  nlf_pkg::byte_t   sentence_byte;
  logic             sentence_last;

  modport source (output valid, output sentence_byte, output sentence_last, input ready);
  modport sink   (input valid, input sentence_byte, input sentence_last, output ready);
endinterface

// ===== rtl/nmea_line_framer_unit.sv =====
// NMEA line framer. Received line bytes are written into a line store with one
// write and one read port; lines start on '$' or '#', CR is ignored, and a line
// longer than LINE_MAX-1 bytes is dropped. A line feed on a non-empty line
// holds off input while its bytes are read out, one store read per cycle
// through the single read port when the read data register can take it, then
// through the output register; output stalls add to the hold-off. The last
// byte of the line carries sentence_last. The output register and the read data
// register together keep one byte per cycle under an output stall-free sink, and
// the input may take a new byte while the final byte still waits.
`include "nmea_line_framer_unit_macros.svh"

module nmea_line_framer_unit #(
  parameter int unsigned LINE_MAX = nlf_pkg::LINE_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nlf_rx_if.sink        rx_i,
  nlf_sent_if.source    sent_o
);

  localparam int unsigned Depth = LINE_MAX - 1;
  localparam int unsigned CntW  = $clog2(LINE_MAX);
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  typedef logic [CntW-1:0] cnt_t;

  state_e           state_q, state_d;
  cnt_t             fill_q, fill_d;
  cnt_t             rd_ptr_q, rd_ptr_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  nlf_pkg::byte_t   rdata_q;
  logic             out_valid_q, out_valid_d;
  nlf_pkg::byte_t   out_byte_q;
  logic             out_last_q;

  nlf_pkg::byte_t   line_store [Depth];

  logic             in_fire, wr_en, rd_en, move, more;
  logic [AddrW-1:0] wr_addr;
  nlf_pkg::byte_t   rx_b;

  assign rx_i.ready           = (state_q == ST_IDLE);
  assign in_fire              = rx_i.valid && rx_i.ready;
  assign rx_b                 = rx_i.rx_byte;

  assign sent_o.valid         = out_valid_q;
  assign sent_o.sentence_byte = out_byte_q;
  assign sent_o.sentence_last = out_last_q;

  // Read-out pipeline: read data register feeds the output register
  assign move  = pend_q && (!out_valid_q || sent_o.ready);
  assign more  = (state_q == ST_DRAIN) && (rd_ptr_q != fill_q);
  assign rd_en = more && (!pend_q || move);

  // Byte handling and drain control
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_ptr_d    = rd_ptr_q;
    wr_en       = 1'b0;
    wr_addr     = fill_q[AddrW-1:0];
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;

    if (in_fire) begin
      if (rx_b == nlf_pkg::CH_CR) begin
        fill_d = fill_q;
      end else if (rx_b == nlf_pkg::CH_LF) begin
        if (fill_q != '0) begin
          state_d  = ST_DRAIN;
          rd_ptr_d = '0;
        end
      end else if (rx_b == nlf_pkg::CH_DOLLAR || rx_b == nlf_pkg::CH_HASH) begin
        // start mark always restarts the line
        wr_en   = 1'b1;
        wr_addr = '0;
        fill_d  = cnt_t'(1);
      end else if (fill_q == '0) begin
        fill_d = '0;
      end else if (fill_q >= cnt_t'(Depth)) begin
        // overlong line: drop it and this byte
        fill_d = '0;
      end else begin
        wr_en  = 1'b1;
        fill_d = cnt_t'(fill_q + cnt_t'(1));
      end
    end

    if (sent_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end
    if (rd_en) begin
      pend_d      = 1'b1;
      pend_last_d = (cnt_t'(rd_ptr_q + cnt_t'(1)) == fill_q);
      rd_ptr_d    = cnt_t'(rd_ptr_q + cnt_t'(1));
    end

    case (state_q)
      ST_IDLE: begin
        // handled above
      end
      ST_DRAIN: begin
        if (!more && !pend_q) begin
          state_d = ST_IDLE;
          fill_d  = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_ptr_q    <= rd_ptr_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Line store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_store[wr_addr] <= rx_b;
    end
    if (rd_en) begin
      rdata_q <= line_store[rd_ptr_q[AddrW-1:0]];
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_byte_q <= rdata_q;
      out_last_q <= pend_last_q;
    end
  end

  `NLF_ASSERT_ALWAYS(a_fill_bound, !rst_ni || (fill_q <= cnt_t'(Depth)), "fill count past depth")
  `NLF_ASSERT(a_no_overwrite, (rd_en && pend_q) |-> move, "read data overwritten before transfer")
  `NLF_ASSERT(a_drain_nonempty, (state_q == ST_IDLE && state_d == ST_DRAIN) |-> (fill_q != '0), "drain started on empty line")
  `NLF_ASSERT(a_ptr_bound, (state_q == ST_DRAIN) |-> (rd_ptr_q <= fill_q), "read pointer past line end")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int LINE_DEPTH  = nlf_pkg::LINE_MAX_DEF - 1;
  localparam int RAND_ITEMS  = 150;
  localparam int CALM_ITEMS  = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 70;
  localparam int DRAIN_WAIT  = nlf_pkg::LINE_MAX_DEF + 16;
  localparam int STALL_LIMIT = 2000;
  localparam int DIR_ROWS    = 22;

  typedef struct packed {
    nlf_pkg::byte_t data;
    logic           last;
  } sent_beat_t;

  // Directed row: byte to send, typed result count (-1: use the predictor), typed bytes
  typedef struct {
    nlf_pkg::byte_t b;
    int             n;
    nlf_pkg::byte_t want [4];
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  nlf_rx_if   rx_bus ();
  nlf_sent_if sent_bus ();

  nmea_line_framer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .sent_o (sent_bus)
  );

  always #5 clk_i = ~clk_i;

  // Framer state mirror
  nlf_pkg::byte_t ln_mem [LINE_DEPTH];
  int             ln_fill = 0;
  sent_beat_t     line_beats [$];   // bytes released by the latest transfer
  sent_beat_t     exp_sent_q [$];   // sentence bytes still owed by the block

  int n_fed       = 0;
  int n_dir       = 0;
  int n_beats     = 0;
  int n_lines     = 0;
  int n_err       = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;
  bit hold_done   = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{nlf_pkg::CH_LF,     0, '{default: 8'h00}},  // line feed on empty store
    '{"A",                0, '{default: 8'h00}},  // dropped while idle
    '{nlf_pkg::CH_CR,     0, '{default: 8'h00}},
    '{nlf_pkg::CH_DOLLAR, 0, '{default: 8'h00}},
    '{"G",                0, '{default: 8'h00}},
    '{nlf_pkg::CH_CR,     0, '{default: 8'h00}},  // ignored mid-line
    '{8'h00,              0, '{default: 8'h00}},  // zero byte is stored
    '{8'hFF,              0, '{default: 8'h00}},
    '{nlf_pkg::CH_LF,     4, '{nlf_pkg::CH_DOLLAR, "G", 8'h00, 8'hFF}},
    '{nlf_pkg::CH_LF,     0, '{default: 8'h00}},
    '{nlf_pkg::CH_HASH,   0, '{default: 8'h00}},
    '{"X",                0, '{default: 8'h00}},
    '{nlf_pkg::CH_DOLLAR, 0, '{default: 8'h00}},  // restart drops "#X"
    '{"Y",                0, '{default: 8'h00}},
    '{nlf_pkg::CH_LF,     2, '{nlf_pkg::CH_DOLLAR, "Y", 8'h00, 8'h00}},
    '{nlf_pkg::CH_HASH,   0, '{default: 8'h00}},
    '{nlf_pkg::CH_HASH,   0, '{default: 8'h00}},  // mark restarts a one-byte line
    '{nlf_pkg::CH_LF,     1, '{nlf_pkg::CH_HASH, 8'h00, 8'h00, 8'h00}},
    '{nlf_pkg::CH_DOLLAR, 0, '{default: 8'h00}},
    '{8'h55,              0, '{default: 8'h00}},
    '{8'hAA,              0, '{default: 8'h00}},
    '{nlf_pkg::CH_LF,    -1, '{default: 8'h00}}
  };

  // Next framer state for one byte; released sentence bytes go to line_beats
  function automatic void frame_predict(input nlf_pkg::byte_t b);
    line_beats.delete();
    if (b == nlf_pkg::CH_CR) return;
    if (b == nlf_pkg::CH_LF) begin
      for (int k = 0; k < ln_fill; k++) begin
        line_beats.push_back('{ln_mem[k], k == ln_fill - 1});
      end
      ln_fill = 0;
      return;
    end
    if (b == nlf_pkg::CH_DOLLAR || b == nlf_pkg::CH_HASH) begin
      ln_fill = 0;
    end else if (ln_fill == 0) begin
      return;
    end
    // overlong line: discard it, drop the byte
    if (ln_fill >= LINE_DEPTH) begin
      ln_fill = 0;
      return;
    end
    ln_mem[ln_fill] = b;
    ln_fill++;
  endfunction

  // Payload byte that keeps a sentence well formed
  function automatic nlf_pkg::byte_t body_byte();
    nlf_pkg::byte_t b;
    do b = nlf_pkg::byte_t'($urandom_range(0, 255));
    while (b == nlf_pkg::CH_CR || b == nlf_pkg::CH_LF ||
           b == nlf_pkg::CH_DOLLAR || b == nlf_pkg::CH_HASH);
    return b;
  endfunction

  // One input transfer, called and returning at a falling edge
  task automatic send_byte(input nlf_pkg::byte_t b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
    n_fed++;
    frame_predict(b);
    @(negedge clk_i);
  endtask

  task automatic feed(input nlf_pkg::byte_t b);
    send_byte(b);
    foreach (line_beats[k]) exp_sent_q.push_back(line_beats[k]);
  endtask

  task automatic feed_line(input int body_len, input bit with_lf);
    feed($urandom_range(0, 1) ? nlf_pkg::CH_DOLLAR : nlf_pkg::CH_HASH);
    repeat (body_len) feed(body_byte());
    if (with_lf) begin
      if ($urandom_range(0, 1)) feed(nlf_pkg::CH_CR);
      feed(nlf_pkg::CH_LF);
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    int si;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    si = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[r]) begin
      send_byte(dir_tab[r].b);
      if (dir_tab[r].n < 0) begin
        foreach (line_beats[k]) exp_sent_q.push_back(line_beats[k]);
      end else begin
        for (int k = 0; k < dir_tab[r].n; k++) begin
          exp_sent_q.push_back('{dir_tab[r].want[k], k == dir_tab[r].n - 1});
        end
      end
    end
    n_dir = n_fed;

    // Mostly well-formed sentences, some noise and broken framing
    while (n_fed - n_dir < RAND_ITEMS) begin
      calm = (n_fed - n_dir >= RAND_ITEMS - CALM_ITEMS);
      if (si == 1) begin
        feed_line(LINE_DEPTH - 1, 1'b1);                          // store exactly full
      end else if (si == 2) begin
        feed_line($urandom_range(LINE_DEPTH, LINE_DEPTH + 1), 1'b1); // overlong
      end else if ($urandom_range(0, 3) != 0) begin
        feed_line($urandom_range(1, 12), 1'b1);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            repeat ($urandom_range(1, 5)) feed(nlf_pkg::byte_t'($urandom_range(0, 255)));
          end
          1: begin
            feed_line($urandom_range(0, 6), 1'b0);                // cut short
          end
          2: begin
            feed(nlf_pkg::CH_LF);
            feed(nlf_pkg::CH_CR);
          end
          default: begin
            feed_line($urandom_range(1, 6), 1'b0);                // restarted mid-line
            feed_line($urandom_range(1, 6), 1'b1);
          end
        endcase
      end
      si++;
    end
    rx_bus.valid <= 1'b0;

    while (exp_sent_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("fed %0d bytes (%0d directed), checked %0d sentence bytes in %0d lines",
             n_fed, n_dir, n_beats, n_lines);
    $display("incl. full-store and overlong lines, output held off %0d cycles once: %0b",
             HOLD_CYCLES, hold_done);
    if (n_err == 0 && exp_sent_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Output ready: random stall bursts, one long hold-off
  initial begin : sink_ready
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    sent_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_beats >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        sent_bus.ready <= 1'b0;
      end else if (calm) begin
        sent_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        sent_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        sent_bus.ready <= 1'b0;
      end else begin
        sent_bus.ready <= 1'b1;
      end
    end
  end

  // Sentence byte checker
  always @(posedge clk_i) begin
    sent_beat_t want;
    if (rst_ni && sent_bus.valid && sent_bus.ready) begin
      n_beats++;
      if (sent_bus.sentence_last) n_lines++;
      if (exp_sent_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected sentence byte %02h last %0b",
                   sent_bus.sentence_byte, sent_bus.sentence_last);
        end
      end else begin
        want = exp_sent_q.pop_front();
        if (sent_bus.sentence_byte !== want.data || sent_bus.sentence_last !== want.last) begin
          n_err++;
          if (n_err <= 10) begin
            $display("sentence byte %0d: expected %02h last %0b, got %02h last %0b",
                     n_beats, want.data, want.last,
                     sent_bus.sentence_byte, sent_bus.sentence_last);
          end
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_bus.valid && rx_bus.ready) || (sent_bus.valid && sent_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d sentence bytes outstanding",
                 idle_cycles, exp_sent_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
